// File: design/vpts_pkg.sv
`default_nettype none

package vpts_pkg;

   localparam int CFG_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PHASE_WIDTH     = 3;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELAY_OPEN_DELAY  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUMPING_TIME      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUMP_OFF_DELAY    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELAY_CLOSE_DELAY = 3'd3;

   // phase codes as reported on the result channel
   localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE  = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_OPEN  = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_PUMP  = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_STOP  = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PHASE_CLOSE = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PHASE_DONE  = 3'd5;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_OPEN  = 6'b000010,
      ST_PUMP  = 6'b000100,
      ST_STOP  = 6'b001000,
      ST_CLOSE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] relay_open_delay;
      logic [CFG_WIDTH-1:0] pumping_time;
      logic [CFG_WIDTH-1:0] pump_off_delay;
      logic [CFG_WIDTH-1:0] relay_close_delay;
   } cfg_type;

   function automatic logic [PHASE_WIDTH-1:0] phase_code(input state_type st);
      logic [PHASE_WIDTH-1:0] code;
      unique case (st)
         ST_OPEN:  code = PHASE_OPEN;
         ST_PUMP:  code = PHASE_PUMP;
         ST_STOP:  code = PHASE_STOP;
         ST_CLOSE: code = PHASE_CLOSE;
         ST_DONE:  code = PHASE_DONE;
         default:  code = PHASE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: design/vpts_ifs.sv
`default_nettype none

interface vpts_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_time;
   logic        run_enable;
   logic        restart;

   modport source (output valid, output now_time, output run_enable, output restart,
                   input ready);
   modport sink   (input valid, input now_time, input run_enable, input restart,
                   output ready);
endinterface

interface vpts_rsp_if;
   logic       valid;
   logic       ready;
   logic       relay_on;
   logic       pump_on;
   logic       run_done;
   logic [2:0] phase;

   modport source (output valid, output relay_on, output pump_on, output run_done,
                   output phase, input ready);
   modport sink   (input valid, input relay_on, input pump_on, input run_done,
                   input phase, output ready);
endinterface

`default_nettype wire

// File: design/valve_pump_timed_sequencer_unit.sv
`default_nettype none

// Six-phase relay and pump sequencer: idle, relay opening, pumping, pump stopping,
// relay closing, done. Each req transaction is one evaluation at the time given in
// now_time; each yields exactly one rsp transaction with the drive levels of the
// phase held when the evaluation began and the phase after it. A transaction is
// taken every cycle while the result side does not stall; the result is presented
// after the input register, then the result register, and the path between them
// is one modular subtract and compare of elapsed time against the phase duration.
// The user must write durations through the csr port (index 0..3) only while no
// transaction is in flight; the block does not enforce this. TIME_WIDTH sets the
// width of the time arithmetic.
module valve_pump_timed_sequencer_unit
   import vpts_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   vpts_req_if.sink                        req,
   vpts_rsp_if.source                      rsp,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]       csr_wdata
);

   cfg_type cfg;

   vpts_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   vpts_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

`ifndef NO_ASSERTIONS
   a_pump_needs_relay: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (!rsp.pump_on || rsp.relay_on))
      else $error("pump driven without relay");

   a_pump_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.pump_on) |-> (rsp.phase == PHASE_PUMP || rsp.phase == PHASE_STOP))
      else $error("pump driven outside pumping");

   a_done_drives_off: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.phase == PHASE_DONE) |-> (!rsp.relay_on && !rsp.pump_on))
      else $error("relay or pump driven on reaching done");
`endif

endmodule

`default_nettype wire

// File: design/vpts_csr.sv
`default_nettype none

module vpts_csr
   import vpts_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] index,
   input  wire logic [CFG_WIDTH-1:0]       wdata,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_RELAY_OPEN_DELAY:  cfg_in.relay_open_delay  = wdata;
            CSR_PUMPING_TIME:      cfg_in.pumping_time      = wdata;
            CSR_PUMP_OFF_DELAY:    cfg_in.pump_off_delay    = wdata;
            CSR_RELAY_CLOSE_DELAY: cfg_in.relay_close_delay = wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: design/vpts_core.sv
`default_nettype none

module vpts_core
   import vpts_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   vpts_req_if.sink              req,
   vpts_rsp_if.source            rsp
);

   // input register stage
   logic        s1_valid_ff;
   logic [31:0] s1_now_ff;
   logic        s1_enable_ff;
   logic        s1_restart_ff;

   // sequencer state
   state_type               state_ff,  state_in;
   logic [TIME_WIDTH-1:0]   start_ff,  start_in;
   logic                    done_ff,   done_in;

   // result register
   logic                    rsp_valid_ff;
   logic                    relay_ff, relay_in;
   logic                    pump_ff,  pump_in;
   logic                    rdone_ff;
   logic [PHASE_WIDTH-1:0]  phase_ff;

   logic                    advance;
   logic                    req_ready;
   logic [TIME_WIDTH-1:0]   now_t;
   logic [TIME_WIDTH-1:0]   elapsed;
   logic [TIME_WIDTH-1:0]   duration;
   logic                    reached;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req_ready = !s1_valid_ff || advance;
   assign req.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req.valid) begin
         s1_now_ff     <= req.now_time;
         s1_enable_ff  <= req.run_enable;
         s1_restart_ff <= req.restart;
      end
   end

   assign now_t   = TIME_WIDTH'(s1_now_ff);
   assign elapsed = now_t - start_ff;

   always_comb begin
      duration = '0;
      unique case (state_ff)
         ST_OPEN:  duration = TIME_WIDTH'(cfg.relay_open_delay);
         ST_PUMP:  duration = TIME_WIDTH'(cfg.pumping_time);
         ST_STOP:  duration = TIME_WIDTH'(cfg.pump_off_delay);
         ST_CLOSE: duration = TIME_WIDTH'(cfg.relay_close_delay);
         default:  duration = '0;
      endcase
   end

   assign reached = elapsed >= duration;

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      done_in  = done_ff;
      relay_in = 1'b0;
      pump_in  = 1'b0;
      unique case (state_ff)
         ST_OPEN: begin
            relay_in = 1'b1;
            if (reached) begin
               state_in = ST_PUMP;
               start_in = now_t;
            end
         end
         ST_PUMP: begin
            relay_in = 1'b1;
            pump_in  = 1'b1;
            if (reached) begin
               state_in = ST_STOP;
               start_in = now_t;
            end
         end
         ST_STOP: begin
            relay_in = 1'b1;
            if (reached) begin
               state_in = ST_CLOSE;
               start_in = now_t;
            end
         end
         ST_CLOSE: begin
            if (reached) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            done_in = 1'b1;
            if (s1_restart_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            done_in  = 1'b0;
            state_in = ST_IDLE;
            if (s1_enable_ff && !s1_restart_ff) begin
               state_in = ST_OPEN;
               start_in = now_t;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            state_ff <= state_in;
            start_ff <= start_in;
            done_ff  <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         relay_ff <= relay_in;
         pump_ff  <= pump_in;
         rdone_ff <= done_in;
         phase_ff <= phase_code(state_in);
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.relay_on = relay_ff;
   assign rsp.pump_on  = pump_ff;
   assign rsp.run_done = rdone_ff;
   assign rsp.phase    = phase_ff;

endmodule

`default_nettype wire

// File: verif/vpts_phase_checker.sv
`timescale 1ns / 1ps

module vpts_phase_checker
   import vpts_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [31:0]                req_now_time,
   input  logic                       req_run_enable,
   input  logic                       req_restart,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_relay_on,
   input  logic                       rsp_pump_on,
   input  logic                       rsp_run_done,
   input  logic [PHASE_WIDTH-1:0]     rsp_phase,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata,
   output int                         pending_results,
   output int                         mismatch_count
);

   typedef struct packed {
      logic                   relay_on;
      logic                   pump_on;
      logic                   run_done;
      logic [PHASE_WIDTH-1:0] phase;
   } drive_word_type;

   logic [CFG_WIDTH-1:0]   duration [4];
   logic [PHASE_WIDTH-1:0] held_phase;
   logic [31:0]            phase_entry_time;
   logic                   done_latch;
   drive_word_type         drive_q [$];
   int                     errors;

   // One evaluation: drive levels come from the phase held on entry.
   function automatic drive_word_type evaluate(input logic [31:0] now, input logic en,
                                               input logic rst);
      drive_word_type w;
      logic [31:0] elapsed;
      w = '0;
      elapsed = now - phase_entry_time;
      case (held_phase)
         PHASE_OPEN: begin
            w.relay_on = 1'b1;
            if (elapsed >= duration[CSR_RELAY_OPEN_DELAY]) begin
               held_phase = PHASE_PUMP;
               phase_entry_time = now;
            end
         end
         PHASE_PUMP: begin
            w.relay_on = 1'b1;
            w.pump_on = 1'b1;
            if (elapsed >= duration[CSR_PUMPING_TIME]) begin
               held_phase = PHASE_STOP;
               phase_entry_time = now;
            end
         end
         PHASE_STOP: begin
            w.relay_on = 1'b1;
            if (elapsed >= duration[CSR_PUMP_OFF_DELAY]) begin
               held_phase = PHASE_CLOSE;
               phase_entry_time = now;
            end
         end
         PHASE_CLOSE: begin
            if (elapsed >= duration[CSR_RELAY_CLOSE_DELAY])
               held_phase = PHASE_DONE;
         end
         PHASE_DONE: begin
            done_latch = 1'b1;
            if (rst)
               held_phase = PHASE_IDLE;
         end
         default: begin
            done_latch = 1'b0;
            held_phase = PHASE_IDLE;
            if (en && !rst) begin
               held_phase = PHASE_OPEN;
               phase_entry_time = now;
            end
         end
      endcase
      w.run_done = done_latch;
      w.phase = held_phase;
      return w;
   endfunction

   always @(posedge clock) begin
      drive_word_type want;
      if (reset) begin
         foreach (duration[i]) duration[i] = '0;
         held_phase = PHASE_IDLE;
         phase_entry_time = '0;
         done_latch = 1'b0;
         drive_q.delete();
      end else begin
         // indexes past the last register are dropped
         if (csr_wr_en && csr_index <= CSR_RELAY_CLOSE_DELAY)
            duration[csr_index[1:0]] = csr_wdata;
         if (req_valid && req_ready)
            drive_q.push_back(evaluate(req_now_time, req_run_enable, req_restart));
         if (rsp_valid && rsp_ready) begin
            if (drive_q.size() == 0) begin
               $error("result transaction with no evaluation pending");
               errors++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_relay_on !== want.relay_on) begin
                  $error("relay_on: expected %0d, actual %0d", want.relay_on, rsp_relay_on);
                  errors++;
               end
               if (rsp_pump_on !== want.pump_on) begin
                  $error("pump_on: expected %0d, actual %0d", want.pump_on, rsp_pump_on);
                  errors++;
               end
               if (rsp_run_done !== want.run_done) begin
                  $error("run_done: expected %0d, actual %0d", want.run_done, rsp_run_done);
                  errors++;
               end
               if (rsp_phase !== want.phase) begin
                  $error("phase: expected %0d, actual %0d", want.phase, rsp_phase);
                  errors++;
               end
            end
         end
      end
      pending_results <= drive_q.size();
      mismatch_count <= errors;
   end

   initial begin
      errors = 0;
      pending_results = 0;
      mismatch_count = 0;
   end

endmodule

// File: verif/tb_valve_pump_timed_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_valve_pump_timed_sequencer_unit
   import vpts_pkg::*;
();

   localparam int IDLE_LIMIT = 2000;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0]       csr_wdata;
   int                         pending_results;
   int                         mismatch_count;
   int                         idle_cycles;
   int                         stall_left;
   int                         calm_left;

   vpts_req_if req_bus ();
   vpts_rsp_if rsp_bus ();

   valve_pump_timed_sequencer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vpts_phase_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_now_time    (req_bus.now_time),
      .req_run_enable  (req_bus.run_enable),
      .req_restart     (req_bus.restart),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_relay_on    (rsp_bus.relay_on),
      .rsp_pump_on     (rsp_bus.pump_on),
      .rsp_run_done    (rsp_bus.run_done),
      .rsp_phase       (rsp_bus.phase),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side back-pressure: mostly short stalls, a few long, calm stretches between.
   always @(negedge clock) begin
      int r;
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         r = $urandom_range(0, 99);
         if (calm_left > 0)
            calm_left--;
         else if (r < 3)
            calm_left = $urandom_range(50, 150);
         else if (r < 60)
            stall_left = 0;
         else if (r < 90)
            stall_left = $urandom_range(1, 3);
         else
            stall_left = $urandom_range(8, 30);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_eval(input logic [31:0] now, input logic en, input logic rst,
                            input bit no_gaps);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55)
         gap = 0;
      else if (r < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 30);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.now_time <= now;
      req_bus.run_enable <= en;
      req_bus.restart <= rst;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold the sender until every evaluation has produced its result.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic program_durations(input logic [31:0] d_open, input logic [31:0] d_pump,
                                    input logic [31:0] d_stop, input logic [31:0] d_close);
      drain_results();
      repeat (3) @(negedge clock);
      write_csr(CSR_RELAY_OPEN_DELAY, d_open);
      write_csr(CSR_PUMPING_TIME, d_pump);
      write_csr(CSR_PUMP_OFF_DELAY, d_stop);
      write_csr(CSR_RELAY_CLOSE_DELAY, d_close);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return $urandom_range(0, 8);
      else if (r < 65)
         return '0;
      else if (r < 85)
         return $urandom_range(9, 120);
      else
         return $urandom;
   endfunction

   // Mostly a time count that creeps forward, with jumps, back-steps and full noise.
   task automatic run_setting(input int count, input logic [31:0] start_at,
                              input bit no_gaps, input bit noisy);
      logic [31:0] t;
      logic        en;
      logic        rst;
      int          r;
      t = start_at;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (noisy) begin
            t = $urandom;
            en = $urandom_range(0, 1);
            rst = $urandom_range(0, 1);
         end else begin
            if (r < 75)
               t += $urandom_range(0, 3);
            else if (r < 88)
               t += $urandom_range(4, 60);
            else if (r < 94)
               t = $urandom;
            else
               t -= $urandom_range(1, 8);
            en = ($urandom_range(0, 99) < 85);
            rst = ($urandom_range(0, 99) < 8);
         end
         if ($urandom_range(0, 99) < 2)
            drain_results();
         send_eval(t, en, rst, no_gaps);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_RELAY_OPEN_DELAY;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.now_time = '0;
      req_bus.run_enable = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      calm_left = 0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero durations after reset: every timed phase ends on its first evaluation
      send_eval(32'h10, 1'b0, 1'b0, 1'b0);
      send_eval(32'h10, 1'b1, 1'b1, 1'b0);   // restart blocks the start
      send_eval(32'h11, 1'b1, 1'b0, 1'b0);
      send_eval(32'h11, 1'b0, 1'b1, 1'b0);   // restart ignored mid-run
      send_eval(32'h12, 1'b0, 1'b0, 1'b0);
      send_eval(32'h12, 1'b0, 1'b0, 1'b0);
      send_eval(32'h13, 1'b1, 1'b0, 1'b0);
      send_eval(32'h13, 1'b1, 1'b0, 1'b0);   // done holds
      send_eval(32'h14, 1'b1, 1'b1, 1'b0);   // leave done, flag still reads set
      send_eval(32'h14, 1'b0, 1'b0, 1'b0);

      // longest durations: elapsed must wrap all the way round
      program_durations('1, '1, '1, '1);
      for (int k = CSR_RELAY_CLOSE_DELAY + 1; k < 2 ** CSR_INDEX_WIDTH; k++)
         write_csr(k[CSR_INDEX_WIDTH-1:0], $urandom);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      send_eval(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0);
      send_eval(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
      send_eval(32'h0000_0005, 1'b0, 1'b0, 1'b0);
      send_eval(32'hFFFF_FFEF, 1'b0, 1'b0, 1'b0);
      send_eval(32'hFFFF_FFEE, 1'b0, 1'b0, 1'b0);
      send_eval(32'hFFFF_FFED, 1'b0, 1'b0, 1'b0);
      send_eval(32'hFFFF_FFEC, 1'b0, 1'b0, 1'b0);
      send_eval(32'hFFFF_FFEC, 1'b0, 1'b1, 1'b0);

      program_durations($urandom_range(0, 6), $urandom_range(0, 6),
                        $urandom_range(0, 6), $urandom_range(0, 6));
      run_setting(205, 32'h0, 1'b0, 1'b0);
      program_durations(pick_duration(), pick_duration(), pick_duration(), pick_duration());
      run_setting(205, 32'hFFFF_FF00, 1'b0, 1'b0);
      program_durations('0, '0, '0, '0);
      run_setting(205, $urandom, 1'b1, 1'b0);
      program_durations(pick_duration(), pick_duration(), pick_duration(), pick_duration());
      run_setting(205, $urandom, 1'b0, 1'b0);
      program_durations(pick_duration(), pick_duration(), pick_duration(), pick_duration());
      run_setting(205, $urandom, 1'b0, 1'b1);
      program_durations($urandom_range(0, 40), $urandom_range(0, 40),
                        $urandom_range(0, 40), $urandom_range(0, 40));
      run_setting(205, 32'hFFFF_FFC0, 1'b0, 1'b0);

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: valve_pump_timed_sequencer_unit.f
design/vpts_pkg.sv
design/vpts_ifs.sv
design/vpts_csr.sv
design/vpts_core.sv
design/valve_pump_timed_sequencer_unit.sv
verif/vpts_phase_checker.sv
verif/tb_valve_pump_timed_sequencer_unit.sv
